@@ hdl/assert_macros.svh @@
// Assertion macros included by the RTL top level.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ttwc_pkg.sv @@
// Shared types and constants for the threshold triggered window capture.
// No dependencies.
package ttwc_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam int SAMPLE_W     = 16;
    localparam int LEVEL_W      = 16;
    localparam int POST_W       = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int DUMP_W       = $clog2(WINDOW_DEPTH);

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(10000);
    localparam logic [POST_W-1:0]  POST_RESET  = POST_W'(5);

    localparam logic CFG_TRIGGER_LEVEL = 1'b0;
    localparam logic CFG_POST_SAMPLES  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic shift;
        logic feedback;
    } t_chain_ctrl;

endpackage

@@ hdl/ttwc_cell.sv @@
// One storage cell of the sample chain: holds a sample, loads its neighbor.
// Depends on ttwc_pkg.
module ttwc_cell
    import ttwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_sample i_data,
    output t_sample o_data
);

    t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ hdl/ttwc_chain.sv @@
// Row of WINDOW_DEPTH cells; newest sample at cell 0, oldest at the tail.
// Depends on ttwc_pkg and ttwc_cell. Feedback rotates the tail into cell 0.
module ttwc_chain
    import ttwc_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  t_sample     i_sample,
    output t_sample     o_tail
);

    t_sample w_q [WINDOW_DEPTH];
    t_sample w_head;

    assign w_head = i_ctrl.feedback ? w_q[WINDOW_DEPTH-1] : i_sample;

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            ttwc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctrl.shift),
                .i_data  (w_head),
                .o_data  (w_q[k])
            );
        end else begin : g_body
            ttwc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctrl.shift),
                .i_data  (w_q[k-1]),
                .o_data  (w_q[k])
            );
        end
    end

    assign o_tail = w_q[WINDOW_DEPTH-1];

endmodule

@@ hdl/threshold_triggered_window_capture.sv @@
// Top level: trigger control, window dump sequencer and output register.
// Depends on ttwc_pkg, ttwc_chain and assert_macros.svh.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  sample    | i_sample_valid/o_sample_ready, i_sample_in | in
//  window    | o_window_valid/i_window_ready,             | out
//            |   o_window_sample, o_window_last           |
//  config    | i_cfg_we, i_cfg_index, i_cfg_wdata         | in
//
// A sample that completes a capture starts a dump: the chain rotates one
// entry per cycle into the output register while the output is not stalled,
// and no sample is taken meanwhile. Reset is synchronous; the chain has no
// reset and no clear pass.
module threshold_triggered_window_capture
    import ttwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sample_valid,
    output logic                  o_sample_ready,
    input  t_sample               i_sample_in,
    output logic                  o_window_valid,
    input  logic                  i_window_ready,
    output t_sample               o_window_sample,
    output logic                  o_window_last,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    typedef enum logic {ST_IDLE, ST_DUMP} t_state;

    t_state              r_state,         n_state;
    logic [LEVEL_W-1:0]  r_trigger_level, n_trigger_level;
    logic [POST_W-1:0]   r_post_samples,  n_post_samples;
    logic [FILL_W-1:0]   r_fill,          n_fill;
    logic                r_armed,         n_armed;
    logic                r_capturing,     n_capturing;
    logic [POST_W-1:0]   r_post_left,     n_post_left;
    logic [DUMP_W-1:0]   r_dump_cnt,      n_dump_cnt;
    logic                r_out_valid,     n_out_valid;
    t_sample             r_out_sample,    n_out_sample;
    logic                r_out_last,      n_out_last;

    logic        w_accept;
    logic        w_out_free;
    logic        w_dump_step;
    logic [16:0] w_mag;
    logic        w_above;
    logic        w_full;
    t_sample     w_tail;
    t_chain_ctrl w_ctrl;

    assign w_accept    = i_sample_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || i_window_ready;
    assign w_dump_step = (r_state == ST_DUMP) && w_out_free;
    assign w_mag       = i_sample_in[SAMPLE_W-1]
                       ? (17'd0 - {i_sample_in[SAMPLE_W-1], i_sample_in})
                       : {1'b0, i_sample_in};
    assign w_above     = w_mag >= {1'b0, r_trigger_level};
    assign w_full      = r_fill >= FILL_W'(WINDOW_DEPTH - 1);

    assign w_ctrl.shift    = w_accept || w_dump_step;
    assign w_ctrl.feedback = (r_state == ST_DUMP);

    ttwc_chain u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_sample (i_sample_in),
        .o_tail   (w_tail)
    );

    always_comb begin
        n_state         = r_state;
        n_trigger_level = r_trigger_level;
        n_post_samples  = r_post_samples;
        n_fill          = r_fill;
        n_armed         = r_armed;
        n_capturing     = r_capturing;
        n_post_left     = r_post_left;
        n_dump_cnt      = r_dump_cnt;
        n_out_valid     = r_out_valid;
        n_out_sample    = r_out_sample;
        n_out_last      = r_out_last;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_LEVEL: n_trigger_level = i_cfg_wdata[LEVEL_W-1:0];
                CFG_POST_SAMPLES:  n_post_samples  = i_cfg_wdata[POST_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_window_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_fill != FILL_W'(WINDOW_DEPTH)) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    if (!r_capturing) begin
                        if (w_above && r_armed && w_full) begin
                            n_capturing = 1'b1;
                            n_armed     = 1'b0;
                            n_post_left = r_post_samples;
                        end else if (!w_above) begin
                            n_armed = 1'b1;
                        end
                    end else if (r_post_left > POST_W'(1)) begin
                        n_post_left = r_post_left - POST_W'(1);
                    end else begin
                        n_capturing = 1'b0;
                        n_post_left = '0;
                        n_dump_cnt  = '0;
                        n_state     = ST_DUMP;
                    end
                end
            end
            ST_DUMP: begin
                if (w_dump_step) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_tail;
                    n_out_last   = (r_dump_cnt == DUMP_W'(WINDOW_DEPTH - 1));
                    n_dump_cnt   = r_dump_cnt + DUMP_W'(1);
                    if (r_dump_cnt == DUMP_W'(WINDOW_DEPTH - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_trigger_level <= LEVEL_RESET;
            r_post_samples  <= POST_RESET;
            r_fill          <= '0;
            r_armed         <= 1'b1;
            r_capturing     <= 1'b0;
            r_post_left     <= '0;
            r_dump_cnt      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_trigger_level <= n_trigger_level;
            r_post_samples  <= n_post_samples;
            r_fill          <= n_fill;
            r_armed         <= n_armed;
            r_capturing     <= n_capturing;
            r_post_left     <= n_post_left;
            r_dump_cnt      <= n_dump_cnt;
            r_out_valid     <= n_out_valid;
        end
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
    end

    assign o_sample_ready  = (r_state == ST_IDLE);
    assign o_window_valid  = r_out_valid;
    assign o_window_sample = r_out_sample;
    assign o_window_last   = r_out_last;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(WINDOW_DEPTH), "fill level overflow")
    `ASSERT_ALWAYS(a_capture_full, i_clk, i_rst_n, !r_capturing || (r_fill == FILL_W'(WINDOW_DEPTH)), "capture with partial window")
    `ASSERT_ALWAYS(a_dump_not_capturing, i_clk, i_rst_n, (r_state != ST_DUMP) || !r_capturing, "dump overlaps capture")
    `ASSERT_NEXT(a_window_hold, i_clk, i_rst_n, o_window_valid && !i_window_ready, o_window_valid && $stable(o_window_sample) && $stable(o_window_last), "window transaction changed while stalled")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for threshold_triggered_window_capture: random and directed
// sample streams, an in-bench capture predictor and a scoreboard on the window channel.
// Depends on ttwc_pkg and the RTL top level only.
module testbench;
    import ttwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES   = 3000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

    typedef struct packed {
        t_sample sample;
        logic    last;
    } window_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  drv_valid = 1'b0;
    t_sample               drv_sample = '0;
    logic                  sample_ready;
    logic                  win_valid;
    logic                  win_ready = 1'b0;
    t_sample               win_sample;
    logic                  win_last;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = CFG_TRIGGER_LEVEL;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic sample_taken = 1'b0;
    logic window_taken = 1'b0;

    t_sample      pending_q[$];
    window_beat_t expected_window_q[$];
    int           samples_queued = 0;
    int           samples_accepted = 0;
    int           error_count = 0;
    int           idle_cycles = 0;
    idle_mode_t   src_idle = IDLE_FULL;
    idle_mode_t   snk_idle = IDLE_FULL;
    bit           long_hold_pending = 1'b0;

    // predictor state
    t_sample            hist_ring [WINDOW_DEPTH];
    int unsigned        hist_slot = 0;
    int unsigned        hist_fill = 0;
    int unsigned        post_left = 0;
    bit                 armed = 1'b1;
    bit                 capturing = 1'b0;
    logic [LEVEL_W-1:0] model_level = LEVEL_RESET;
    logic [POST_W-1:0]  model_post = POST_RESET;

    int directed_samples [25] = '{32767, -32768, 0, -1, 1, 9999, -9999, 10000, -10000, 20000,
                                  5, -5, 32767, -32768, 123,
                                  -20000, 9999, -10000, 0, 1, 2, 3, 4, -32768, 0};

    threshold_triggered_window_capture dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_sample_valid  (drv_valid),
        .o_sample_ready  (sample_ready),
        .i_sample_in     (drv_sample),
        .o_window_valid  (win_valid),
        .i_window_ready  (win_ready),
        .o_window_sample (win_sample),
        .o_window_last   (win_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic int draw_wait(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 19);
            default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    function automatic void predict_capture(t_sample s);
        logic [SAMPLE_W:0] mag;
        bit                above;
        int unsigned       slot;
        window_beat_t      beat;
        mag   = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
        above = (mag >= {1'b0, model_level});
        hist_ring[hist_slot] = s;
        hist_slot = (hist_slot + 1) % WINDOW_DEPTH;
        if (hist_fill < WINDOW_DEPTH)
            hist_fill++;
        if (!capturing) begin
            if (above && armed && hist_fill >= WINDOW_DEPTH) begin
                capturing = 1'b1;
                armed     = 1'b0;
                post_left = model_post;
            end else if (!above) begin
                armed = 1'b1;
            end
        end else if (post_left > 1) begin
            post_left--;
        end else begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                slot = (hist_slot + k) % WINDOW_DEPTH;
                beat.sample = hist_ring[slot];
                beat.last   = (k == WINDOW_DEPTH - 1);
                expected_window_q.push_back(beat);
            end
            capturing = 1'b0;
            post_left = 0;
        end
    endfunction

    // sample driver
    always @(negedge clk) begin : sample_driver
        logic    nxt_valid;
        t_sample nxt_sample;
        int      gap_left;
        nxt_valid  = drv_valid;
        nxt_sample = drv_sample;
        if (rst_n) begin
            if (drv_valid && sample_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    nxt_sample = pending_q.pop_front();
                    nxt_valid  = 1'b1;
                    gap_left   = draw_wait(src_idle);
                end
            end
        end
        drv_valid  <= nxt_valid;
        drv_sample <= nxt_sample;
    end

    // window receiver
    always @(negedge clk) begin : window_receiver
        logic nxt_ready;
        int   wait_left;
        nxt_ready = win_ready;
        if (rst_n) begin
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                wait_left = LONG_HOLD_CYCLES;
                nxt_ready = 1'b0;
            end else if (win_ready) begin
                if (window_taken) begin
                    wait_left = draw_wait(snk_idle);
                    nxt_ready = (wait_left == 0);
                end
            end else if (wait_left > 0) begin
                wait_left--;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        win_ready <= nxt_ready;
    end

    // monitor and scoreboard
    always @(posedge clk) begin : monitor
        window_beat_t exp_beat;
        if (!rst_n) begin
            sample_taken <= 1'b0;
            window_taken <= 1'b0;
        end else begin
            sample_taken <= drv_valid && sample_ready;
            window_taken <= win_valid && win_ready;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TRIGGER_LEVEL: model_level = cfg_wdata[LEVEL_W-1:0];
                    CFG_POST_SAMPLES:  model_post  = cfg_wdata[POST_W-1:0];
                endcase
            end
            if (drv_valid && sample_ready) begin
                predict_capture(drv_sample);
                samples_accepted++;
            end
            if (win_valid && win_ready) begin
                if (expected_window_q.size() == 0) begin
                    $error("unexpected window transaction: window_sample %0d window_last %0b",
                           win_sample, win_last);
                    error_count++;
                end else begin
                    exp_beat = expected_window_q.pop_front();
                    if (win_sample !== exp_beat.sample) begin
                        $error("window_sample: expected %0d, actual %0d",
                               exp_beat.sample, win_sample);
                        error_count++;
                    end
                    if (win_last !== exp_beat.last) begin
                        $error("window_last: expected %0b, actual %0b", exp_beat.last, win_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((drv_valid && sample_ready) || (win_valid && win_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= TIMEOUT_CYCLES) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic t_sample from_magnitude(int m, bit neg);
        int v;
        v = neg ? -m : m;
        return t_sample'(v);
    endfunction

    // magnitude strictly below level; any value when level is 0
    function automatic t_sample quiet_sample(int lvl);
        int lim;
        int m;
        if (lvl == 0)
            return t_sample'($urandom);
        lim = (lvl - 1 > 32768) ? 32768 : lvl - 1;
        m = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(0, lim);
        return from_magnitude(m, $urandom_range(0, 1));
    endfunction

    // magnitude at or above level; any value when level exceeds 32768
    function automatic t_sample loud_sample(int lvl);
        int m;
        if (lvl > 32768)
            return t_sample'($urandom);
        m = ($urandom_range(0, 3) == 0) ? lvl : $urandom_range(lvl, 32768);
        return from_magnitude(m, $urandom_range(0, 1));
    endfunction

    task automatic queue_sample(t_sample s);
        pending_q.push_back(s);
        samples_queued++;
    endtask

    task automatic wait_idle();
        while (samples_accepted != samples_queued || expected_window_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(int lvl, int post, int n_items, idle_mode_t src,
                             idle_mode_t snk, bit hold);
        int cnt;
        cnt = 0;
        wait_idle();
        write_reg(CFG_TRIGGER_LEVEL, CFG_DATA_W'(lvl));
        write_reg(CFG_POST_SAMPLES, {12'($urandom), 4'(post)});
        src_idle = src;
        snk_idle = snk;
        if (hold)
            long_hold_pending = 1'b1;
        while (cnt < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                // arm, trigger, then post-trigger samples with random content
                repeat ($urandom_range(1, 3)) begin
                    queue_sample(quiet_sample(lvl));
                    cnt++;
                end
                queue_sample(loud_sample(lvl));
                cnt++;
                repeat (post + $urandom_range(0, 2)) begin
                    queue_sample($urandom_range(0, 1) ? quiet_sample(lvl)
                                                      : t_sample'($urandom));
                    cnt++;
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    queue_sample(t_sample'($urandom));
                    cnt++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_samples[i])
            queue_sample(t_sample'(directed_samples[i]));

        run_phase(10000, 1, 60, IDLE_NONE, IDLE_NONE, 1'b1);
        run_phase(0, 0, 40, IDLE_FULL, IDLE_SPARSE, 1'b0);
        run_phase(65535, 15, 30, IDLE_SPARSE, IDLE_FULL, 1'b0);
        run_phase(32768, 15, 60, IDLE_SPARSE, IDLE_NONE, 1'b0);
        run_phase(1, 0, 60, IDLE_NONE, IDLE_FULL, 1'b0);
        repeat (3)
            run_phase($urandom_range(0, 32768), $urandom_range(0, 15), 60,
                      idle_mode_t'($urandom_range(0, 2)), idle_mode_t'($urandom_range(0, 2)),
                      1'b0);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ttwc_pkg.sv
hdl/ttwc_cell.sv
hdl/ttwc_chain.sv
hdl/threshold_triggered_window_capture.sv
sim/testbench.sv
